>>> sv/ccv_pkg.sv
package ccv_pkg;

  // Crossing fraction: quotient bits produced by the divider (value <= 2^24)
  localparam int QUOT_W = 25;
  // Corner magnitude width (|corner - contour| < 2^32)
  localparam int MAG_W = 32;

  // One grid cell
  typedef struct packed {
    logic signed [31:0] z_sw;
    logic signed [31:0] z_se;
    logic signed [31:0] z_ne;
    logic signed [31:0] z_nw;
    logic               cell_valid;
    logic [23:0]        row_weight;
    logic               last_cell;
  } item_t;

  // Emitted totals
  typedef struct packed {
    logic signed [63:0] total_volume;
    logic [62:0]        total_area;
  } result_t;

  // Configuration registers
  typedef struct packed {
    logic signed [31:0] contour_level;
    logic               base_enable;
    logic signed [31:0] base_level;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] m0;
    logic [MAG_W-1:0] m1;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> sv/ccv_div.sv
// Restoring divider: quot = floor(m0 * 2^24 / (m0 + m1)), one bit per cycle
module ccv_div (
  input  logic             clk,
  input  logic             rst,
  input  ccv_pkg::div_req_t req,
  output ccv_pkg::div_rsp_t rsp
);
  import ccv_pkg::*;

  logic [MAG_W:0]    den;
  logic [MAG_W:0]    rem;
  logic [QUOT_W-1:0] quot;
  logic [4:0]        cnt;
  logic              busy;
  logic              done;
  logic              nbit;
  logic [MAG_W+1:0]  trial;
  logic              fits;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, nbit};
    fits  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      // high part m0>>1 is below den, so only 25 quotient bits remain
      den  <= {1'b0, req.m0} + {1'b0, req.m1};
      rem  <= {2'b0, req.m0[MAG_W-1:1]};
      nbit <= req.m0[0];
      cnt  <= 5'(QUOT_W);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= fits ? 33'(trial - {1'b0, den}) : trial[MAG_W:0];
      quot <= {quot[QUOT_W-2:0], fits};
      nbit <= 1'b0;
      cnt  <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

>>> sv/ccv_mul.sv
// Shared signed multiplier with registered product
module ccv_mul (
  input  logic                clk,
  input  logic                en,
  input  logic signed [35:0]  a,
  input  logic signed [33:0]  b,
  output logic signed [69:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

>>> sv/ccv_core.sv
// Cell sequencer: classify, integrate pieces, accumulate, emit
module ccv_core (
  input  logic              clk,
  input  logic              rst,
  input  ccv_pkg::cfg_t     cfg,
  input  logic              start,
  input  ccv_pkg::item_t    item,
  output logic              idle,
  output logic              res_valid,
  output ccv_pkg::result_t  res,
  input  logic              out_free
);
  import ccv_pkg::*;

  localparam logic [24:0] ONE_CELL = 25'h1000000;
  localparam logic [31:0] RECIP3   = 32'hAAAAAAAB;
  localparam logic [62:0] AREA_MAX = {63{1'b1}};
  localparam logic signed [63:0] VOL_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] VOL_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_CLASS, S_DIVP_GO, S_DIVP_WAIT, S_DIVQ_GO, S_DIVQ_WAIT,
    S_MUL_ISS, S_MUL_WB, S_PIECE_END, S_ACC_ISS, S_ACC_WB, S_AREA_ISS,
    S_AREA_WB, S_EMIT, S_BASE0_ISS, S_BASE0_WB, S_BASE1_ISS, S_BASE1_WB,
    S_BASE_FIN, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    ST_PQ, ST_X, ST_Y, ST_Z, ST_C2, ST_C3, ST_C4, ST_TA, ST_TB, ST_TC, ST_TD
  } step_t;

  // corner triangles at sw/se/ne/nw, and strips along east or north
  typedef enum logic [2:0] {
    K_C0, K_C1, K_C2, K_C3, K_S13, K_S31
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  keep;
  } piece_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [63:0] s;
    s = x + y;
    if (!x[63] && !y[63] && s[63]) return VOL_MAX;
    if (x[63] && y[63] && !s[63]) return VOL_MIN;
    return s;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [32:0] x);
    logic signed [32:0] n;
    n = x[32] ? -x : x;
    return n[MAG_W-1:0];
  endfunction

  state_t state;
  step_t  step;
  item_t  item_q;

  logic signed [32:0] h0, h1, h2, h3;
  logic signed [57:0] full;
  logic signed [63:0] v;
  logic signed [63:0] tv;
  logic [25:0]        ar;
  logic [24:0]        p, q, pq, x, y, z;
  logic [23:0]        c2, c3, c4;
  piece_t             pc0, pc1;
  logic               two;
  logic               pidx;
  logic signed [63:0] volume_sum;
  logic [62:0]        area_sum;
  logic [32:0]        negt;
  logic [64:0]        p0;
  logic [63:0]        p1;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               mul_en;
  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [69:0] prod;

  // corner heights relative to the contour, exact zero bumped to +1
  logic signed [32:0] hd0, hd1, hd2, hd3;
  always_comb begin
    hd0 = 33'(item_q.z_sw) - 33'(cfg.contour_level);
    hd1 = 33'(item_q.z_se) - 33'(cfg.contour_level);
    hd2 = 33'(item_q.z_ne) - 33'(cfg.contour_level);
    hd3 = 33'(item_q.z_nw) - 33'(cfg.contour_level);
    if (hd0 == '0) hd0 = 33'sd1;
    if (hd1 == '0) hd1 = 33'sd1;
    if (hd2 == '0) hd2 = 33'sd1;
    if (hd3 == '0) hd3 = 33'sd1;
  end

  // classification
  logic [3:0]         le1, sgn, cut;
  logic signed [57:0] sum58, full_c;
  piece_t             pc0_c, pc1_c;
  logic               two_c;
  always_comb begin
    le1   = {h3 <= 33'sd1, h2 <= 33'sd1, h1 <= 33'sd1, h0 <= 33'sd1};
    sgn   = {h3[32], h2[32], h1[32], h0[32]};
    cut   = {sgn[3] ^ sgn[0], sgn[2] ^ sgn[3], sgn[1] ^ sgn[2], sgn[0] ^ sgn[1]};
    sum58 = 58'(h0) + 58'(h1) + 58'(h2) + 58'(h3);
    full_c = sum58 <<< 22;
    two_c = 1'b0;
    pc0_c = '{kind: K_C0, keep: ~sgn[0]};
    pc1_c = '{kind: K_C2, keep: 1'b1};
    if (&cut) begin
      // saddle: two kept triangles at the positive diagonal
      two_c = 1'b1;
      if (!sgn[0]) begin
        pc0_c = '{kind: K_C0, keep: 1'b1};
        pc1_c = '{kind: K_C2, keep: 1'b1};
      end else begin
        pc0_c = '{kind: K_C1, keep: 1'b1};
        pc1_c = '{kind: K_C3, keep: 1'b1};
      end
    end else if (cut[0]) begin
      if (cut[1])      pc0_c = '{kind: K_C1, keep: ~sgn[1]};
      else if (cut[2]) pc0_c = '{kind: K_S13, keep: ~sgn[0]};
      else             pc0_c = '{kind: K_C0, keep: ~sgn[0]};
    end else if (cut[1]) begin
      if (cut[2]) pc0_c = '{kind: K_C2, keep: ~sgn[2]};
      else        pc0_c = '{kind: K_S31, keep: ~sgn[0]};
    end else begin
      pc0_c = '{kind: K_C3, keep: ~sgn[3]};
    end
  end

  // current piece: base corner, x and y neighbors, diagonal
  piece_t             pc;
  logic               strip;
  logic signed [32:0] e0, ex, ey, ed;
  logic signed [35:0] ca, cb, cc, cd;
  always_comb begin
    pc    = pidx ? pc1 : pc0;
    strip = (pc.kind == K_S13) || (pc.kind == K_S31);
    case (pc.kind)
      K_C1: begin
        e0 = h1; ex = h0; ey = h2; ed = h3;
      end
      K_C2: begin
        e0 = h2; ex = h3; ey = h1; ed = h0;
      end
      K_C3: begin
        e0 = h3; ex = h2; ey = h0; ed = h1;
      end
      K_S31: begin
        e0 = h0; ex = h3; ey = h1; ed = h2;
      end
      default: begin
        e0 = h0; ex = h1; ey = h3; ed = h2;
      end
    endcase
    ca = 36'(e0);
    cb = 36'(ex) - 36'(e0);
    cc = 36'(ey) - 36'(e0);
    cd = 36'(ed) + 36'(e0) - 36'(ex) - 36'(ey);
  end

  // moment numerators and first coefficient
  logic [26:0] n2, n3, n4;
  logic [25:0] spq;
  logic [24:0] c1;
  always_comb begin
    spq = 26'(p) + 26'(q);
    c1  = strip ? spq[25:1] : {1'b0, pq[24:1]};
    n2  = strip ? (27'(x) + 27'(pq) + 27'(y)) : 27'(x);
    n3  = strip ? (27'(p) + {1'b0, q, 1'b0}) : 27'(y);
    n4  = strip ? (27'(x) + {1'b0, pq, 1'b0} + 27'(y) + {1'b0, y, 1'b0}) : 27'(z);
  end

  // divider operands
  always_comb begin
    div_req.start = (state == S_DIVP_GO) || (state == S_DIVQ_GO);
    if (state == S_DIVP_GO) begin
      div_req.m0 = mag(e0);
      div_req.m1 = mag(ex);
    end else if (strip) begin
      div_req.m0 = mag(ey);
      div_req.m1 = mag(ed);
    end else begin
      div_req.m0 = mag(e0);
      div_req.m1 = mag(ey);
    end
  end

  // multiplier operands
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_MUL_ISS: begin
        mul_en = 1'b1;
        case (step)
          ST_PQ: begin
            mul_a = {11'd0, p};  mul_b = {9'd0, q};
          end
          ST_X: begin
            mul_a = {11'd0, strip ? p : pq};  mul_b = {9'd0, p};
          end
          ST_Y: begin
            mul_a = {11'd0, strip ? q : pq};  mul_b = {9'd0, q};
          end
          ST_Z: begin
            mul_a = {11'd0, pq};  mul_b = {9'd0, pq};
          end
          ST_C2: begin
            mul_a = {10'd0, n2[26:1]};  mul_b = {2'd0, RECIP3};
          end
          ST_C3: begin
            mul_a = {10'd0, n3[26:1]};  mul_b = {2'd0, RECIP3};
          end
          ST_C4: begin
            mul_a = {12'd0, n4[26:3]};  mul_b = {2'd0, RECIP3};
          end
          ST_TA: begin
            mul_a = ca;  mul_b = {9'd0, c1};
          end
          ST_TB: begin
            mul_a = cb;  mul_b = {10'd0, c2};
          end
          ST_TC: begin
            mul_a = cc;  mul_b = {10'd0, c3};
          end
          default: begin
            mul_a = cd;  mul_b = {10'd0, c4};
          end
        endcase
      end
      S_ACC_ISS: begin
        mul_en = 1'b1;
        mul_a  = v[59:24];
        mul_b  = {10'd0, item_q.row_weight};
      end
      S_AREA_ISS: begin
        mul_en = 1'b1;
        mul_a  = {10'd0, ar};
        mul_b  = {10'd0, item_q.row_weight};
      end
      S_BASE0_ISS: begin
        mul_en = 1'b1;
        mul_a  = {4'd0, area_sum[31:0]};
        mul_b  = {1'b0, negt};
      end
      S_BASE1_ISS: begin
        mul_en = 1'b1;
        mul_a  = {5'd0, area_sum[62:32]};
        mul_b  = {1'b0, negt};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // base correction terms
  logic signed [32:0] tdiff;
  logic [95:0]        prod96;
  logic [63:0]        corr;
  logic [49:0]        aw;
  logic [62:0]        room;
  logic signed [63:0] piece_v;
  always_comb begin
    tdiff   = 33'(cfg.base_level) - 33'(cfg.contour_level);
    prod96  = {31'd0, p0} + {p1, 32'd0};
    corr    = ((|prod96[95:88]) || prod96[87]) ? VOL_MAX : prod96[87:24];
    aw      = prod[49:0];
    room    = AREA_MAX - 63'(aw);
    piece_v = pc.keep ? tv : (64'(full) - tv);
  end

  ccv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ccv_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= ST_PQ;
      pidx       <= 1'b0;
      two        <= 1'b0;
      volume_sum <= '0;
      area_sum   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          h0    <= hd0;
          h1    <= hd1;
          h2    <= hd2;
          h3    <= hd3;
          v     <= '0;
          ar    <= '0;
          pidx  <= 1'b0;
          state <= S_CLASS;
        end
        S_CLASS: begin
          full <= full_c;
          pc0  <= pc0_c;
          pc1  <= pc1_c;
          two  <= two_c;
          if (!item_q.cell_valid || (&le1)) begin
            state <= S_EMIT;
          end else if (~|le1) begin
            v     <= 64'(full_c);
            ar    <= 26'(ONE_CELL);
            state <= S_ACC_ISS;
          end else if (~|cut) begin
            state <= S_EMIT;
          end else begin
            state <= S_DIVP_GO;
          end
        end
        S_DIVP_GO: state <= S_DIVP_WAIT;
        S_DIVP_WAIT: begin
          if (div_rsp.done) begin
            p     <= div_rsp.quot;
            state <= S_DIVQ_GO;
          end
        end
        S_DIVQ_GO: state <= S_DIVQ_WAIT;
        S_DIVQ_WAIT: begin
          if (div_rsp.done) begin
            q     <= div_rsp.quot;
            step  <= ST_PQ;
            state <= S_MUL_ISS;
          end
        end
        S_MUL_ISS: state <= S_MUL_WB;
        S_MUL_WB: begin
          case (step)
            ST_PQ:   pq <= prod[48:24];
            ST_X:    x  <= prod[48:24];
            ST_Y:    y  <= prod[48:24];
            ST_Z:    z  <= prod[48:24];
            ST_C2:   c2 <= prod[56:33];
            ST_C3:   c3 <= prod[56:33];
            ST_C4:   c4 <= prod[56:33];
            ST_TA:   tv <= prod[63:0];
            default: tv <= tv + prod[63:0];
          endcase
          if (step == ST_TD) begin
            state <= S_PIECE_END;
          end else begin
            step  <= step_t'(4'(step) + 4'd1);
            state <= S_MUL_ISS;
          end
        end
        S_PIECE_END: begin
          v  <= v + piece_v;
          ar <= ar + (pc.keep ? 26'(c1) : (26'(ONE_CELL) - 26'(c1)));
          if (two && !pidx) begin
            pidx  <= 1'b1;
            state <= S_DIVP_GO;
          end else begin
            state <= S_ACC_ISS;
          end
        end
        S_ACC_ISS: state <= S_ACC_WB;
        S_ACC_WB: begin
          volume_sum <= sat_add(volume_sum, prod[63:0]);
          state      <= S_AREA_ISS;
        end
        S_AREA_ISS: state <= S_AREA_WB;
        S_AREA_WB: begin
          area_sum <= (area_sum > room) ? AREA_MAX : (area_sum + 63'(aw));
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!item_q.last_cell) begin
            state <= S_IDLE;
          end else if (!cfg.base_enable) begin
            res.total_volume <= volume_sum;
            res.total_area   <= area_sum;
            state            <= S_OUT;
          end else if (!tdiff[32]) begin
            res   <= '0;
            state <= S_OUT;
          end else begin
            negt  <= -tdiff;
            state <= S_BASE0_ISS;
          end
        end
        S_BASE0_ISS: state <= S_BASE0_WB;
        S_BASE0_WB: begin
          p0    <= prod[64:0];
          state <= S_BASE1_ISS;
        end
        S_BASE1_ISS: state <= S_BASE1_WB;
        S_BASE1_WB: begin
          p1    <= prod[63:0];
          state <= S_BASE_FIN;
        end
        S_BASE_FIN: begin
          res.total_volume <= sat_add(volume_sum, corr);
          res.total_area   <= area_sum;
          state            <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            volume_sum <= '0;
            area_sum   <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("cell started while sequencer busy");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVP_WAIT || state == S_DIVQ_WAIT))
    else $error("divider finished outside a wait state");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_free) |=> (state == S_OUT && $stable(res)))
    else $error("totals changed while waiting for output slot");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (volume_sum == '0 && area_sum == '0))
    else $error("sums not cleared after emission");

endmodule

>>> sv/contour_clipped_cell_volume.sv
// Channel  | Handshake                    | Payload
// item     | item_valid / item_ready      | ccv_pkg::item_t  (one cell)
// result   | result_valid / result_ready  | ccv_pkg::result_t (totals, last cell only)
// config   | psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// One cell at a time; item_ready is low while a cell is in work.
// Skipped or invalid cells go from classification straight to emission,
// fully-above cells through accumulation. Each clipped piece takes two
// 25-step divisions in the shared divider and eleven passes through the
// shared multiplier; a saddle cell has two pieces.
// Reset is synchronous and clears the sums and the configuration.
// A finished result waits in the output register; a new cell may enter
// meanwhile, and only the next emission waits for the slot to free.
module contour_clipped_cell_volume (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_ready,
  input  ccv_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output ccv_pkg::result_t  result
);
  import ccv_pkg::*;

  localparam logic [1:0] REG_CONTOUR  = 2'd0;
  localparam logic [1:0] REG_BASE_EN  = 2'd1;
  localparam logic [1:0] REG_BASE_LVL = 2'd2;

  cfg_t    cfg;
  logic    core_idle;
  logic    core_res_valid;
  result_t core_res;
  logic    out_free;
  logic    wr;

  // register writes
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_CONTOUR:  cfg.contour_level <= pwdata;
        REG_BASE_EN:  cfg.base_enable   <= pwdata[0];
        REG_BASE_LVL: cfg.base_level    <= pwdata;
        default:      cfg <= cfg;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_CONTOUR:  prdata = cfg.contour_level;
      REG_BASE_EN:  prdata = {31'd0, cfg.base_enable};
      REG_BASE_LVL: prdata = cfg.base_level;
      default:      prdata = '0;
    endcase
  end

  assign item_ready = core_idle;
  assign out_free   = !result_valid || result_ready;

  ccv_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (item_valid && item_ready),
    .item      (item),
    .idle      (core_idle),
    .res_valid (core_res_valid),
    .res       (core_res),
    .out_free  (out_free)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (core_res_valid && out_free) begin
      result_valid <= 1'b1;
      result       <= core_res;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ccv_pkg::*;

  localparam logic [3:0] ADDR_CONTOUR   = 4'd0;
  localparam logic [3:0] ADDR_BASE_EN   = 4'd4;
  localparam logic [3:0] ADDR_BASE_LVL  = 4'd8;
  localparam longint     CYCLE_LIMIT    = 4000000;
  localparam logic [63:0] ONE_CELL      = 64'd1 << 24;
  localparam longint     AREA_CAP       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint     VOL_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint     VOL_MIN        = 64'sh8000_0000_0000_0000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic item_valid, item_ready, result_valid, result_ready;
  item_t item;
  result_t result;

  contour_clipped_cell_volume dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  // Shadow of configuration and running sums
  longint     level_q, base_q;
  bit         base_en_q;
  longint     vol_acc;
  logic [63:0] area_acc;
  result_t    totals_q[$];
  int         errors, cells_sent, totals_seen;
  longint     cycles;
  bit         calm;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Global cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL contour_clipped_cell_volume");
      $finish;
    end
  end

  function automatic longint sat_sum(longint x, longint y);
    if (y > 0 && x > VOL_MAX - y) return VOL_MAX;
    if (y < 0 && x < VOL_MIN - y) return VOL_MIN;
    return x + y;
  endfunction

  function automatic logic [63:0] mag64(longint h);
    return h < 0 ? 64'(-h) : 64'(h);
  endfunction

  function automatic logic [63:0] frac_mul(logic [63:0] x, logic [63:0] y);
    logic [63:0] p;
    p = x * y;
    return p >> 24;
  endfunction

  function automatic logic [63:0] cross_frac(longint h0, longint h1);
    logic [63:0] m0, m1;
    m0 = mag64(h0);
    m1 = mag64(h1);
    return (m0 << 24) / (m0 + m1);
  endfunction

  // Corner triangle piece
  task automatic tri_piece(input longint h0, hx, hy, hd, input bit keep, input longint full,
                           inout longint v, inout logic [63:0] ar);
    logic [63:0] p, q, pq, ta;
    longint tv;
    p = cross_frac(h0, hx);
    q = cross_frac(h0, hy);
    pq = frac_mul(p, q);
    tv = h0 * longint'(pq >> 1) + (hx - h0) * longint'(frac_mul(pq, p) / 6)
       + (hy - h0) * longint'(frac_mul(pq, q) / 6)
       + (hd + h0 - hx - hy) * longint'(frac_mul(pq, pq) / 24);
    ta = pq >> 1;
    if (keep) begin
      v += tv; ar += ta;
    end else begin
      v += full - tv; ar += ONE_CELL - ta;
    end
  endtask

  // Trapezoid strip piece
  task automatic band_piece(input longint h0, along, across, twist,
                            input logic [63:0] p, q, input bit keep, input longint full,
                            inout longint v, inout logic [63:0] ar);
    logic [63:0] pp, pq, qq, ta;
    longint tv;
    pp = frac_mul(p, p);
    pq = frac_mul(p, q);
    qq = frac_mul(q, q);
    tv = h0 * longint'((p + q) >> 1) + along * longint'((pp + pq + qq) / 6)
       + across * longint'((p + 2 * q) / 6)
       + twist * longint'((pp + 2 * pq + 3 * qq) / 24);
    ta = (p + q) >> 1;
    if (keep) begin
      v += tv; ar += ta;
    end else begin
      v += full - tv; ar += ONE_CELL - ta;
    end
  endtask

  // Clip one cell against the contour and fold it into the sums
  task automatic clip_cell(input item_t c);
    longint h[4];
    bit cut[4];
    int below, ncut;
    longint v, full, cv, a, b, cc, d;
    logic [63:0] ar, aw, w;
    v = 0; ar = 0; below = 0; ncut = 0;
    w = 64'(c.row_weight);
    h[0] = longint'(c.z_sw) - level_q;
    h[1] = longint'(c.z_se) - level_q;
    h[2] = longint'(c.z_ne) - level_q;
    h[3] = longint'(c.z_nw) - level_q;
    for (int k = 0; k < 4; k++) begin
      if (h[k] == 0) h[k] = 1;
      if (h[k] <= 1) below++;
    end
    if (below == 4) return;
    a = h[0]; b = h[1]; cc = h[2]; d = h[3];
    full = (a + b + cc + d) * longint'(ONE_CELL >> 2);
    if (below == 0) begin
      v = full; ar = ONE_CELL;
    end else begin
      for (int k = 0; k < 4; k++) begin
        cut[k] = (h[k] < 0) != (h[(k + 1) % 4] < 0);
        if (cut[k]) ncut++;
      end
      if (ncut < 2) return;
      if (ncut == 4) begin
        if (a > 0) begin
          tri_piece(a, b, d, cc, 1, full, v, ar);
          tri_piece(cc, d, b, a, 1, full, v, ar);
        end else begin
          tri_piece(b, a, cc, d, 1, full, v, ar);
          tri_piece(d, cc, a, b, 1, full, v, ar);
        end
      end else if (cut[0]) begin
        if (cut[1]) tri_piece(b, a, cc, d, b > 0, full, v, ar);
        else if (cut[2])
          band_piece(a, b - a, d - a, a + cc - b - d, cross_frac(a, b), cross_frac(d, cc),
                     a > 0, full, v, ar);
        else tri_piece(a, b, d, cc, a > 0, full, v, ar);
      end else if (cut[1]) begin
        if (cut[2]) tri_piece(cc, d, b, a, cc > 0, full, v, ar);
        else
          band_piece(a, d - a, b - a, a + cc - b - d, cross_frac(a, d), cross_frac(b, cc),
                     a > 0, full, v, ar);
      end else begin
        tri_piece(d, cc, a, b, d > 0, full, v, ar);
      end
    end
    cv = (v >= 0) ? (v >>> 24) : -longint'((64'(-v) + ONE_CELL - 1) >> 24);
    vol_acc = sat_sum(vol_acc, cv * longint'(w));
    aw = ar * w;
    area_acc = (area_acc > AREA_CAP - aw) ? AREA_CAP : area_acc + aw;
  endtask

  // Predict the totals for one accepted cell
  task automatic predict_cell(input item_t c);
    result_t r;
    longint vol, t, corr;
    logic [63:0] area;
    logic [127:0] prod;
    if (c.cell_valid) clip_cell(c);
    if (!c.last_cell) return;
    vol = vol_acc;
    area = (area_acc > AREA_CAP) ? AREA_CAP : area_acc;
    if (base_en_q) begin
      t = base_q - level_q;
      if (t >= 0) begin
        vol = 0; area = 0;
      end else begin
        prod = 128'(area) * 128'(64'(-t));
        prod = prod >> 24;
        corr = (prod > 128'(VOL_MAX)) ? VOL_MAX : longint'(prod[63:0]);
        vol = sat_sum(vol, corr);
      end
    end
    r.total_volume = vol;
    r.total_area = area[62:0];
    totals_q.push_back(r);
    vol_acc = 0;
    area_acc = 0;
  endtask

  // Result check and receiver stalls
  initial begin
    int stall;
    result_ready = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        if (totals_q.size() == 0) begin
          $display("%0t unexpected totals: volume %0d area %0d", $time,
                   result.total_volume, result.total_area);
          errors++;
        end else begin
          result_t e;
          e = totals_q.pop_front();
          if (result.total_volume !== e.total_volume) begin
            $display("%0t volume mismatch: expected %0d actual %0d", $time,
                     e.total_volume, result.total_volume);
            errors++;
          end
          if (result.total_area !== e.total_area) begin
            $display("%0t area mismatch: expected %0d actual %0d", $time,
                     e.total_area, result.total_area);
            errors++;
          end
        end
        totals_seen++;
      end
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 9);
      result_ready <= (stall == 0);
    end
  end

  // Send one cell; the predictor runs on acceptance. Valid stays up after
  // acceptance so back-to-back cells follow; idling and drain drop it.
  task automatic send_cell(input item_t c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item <= c;
    item_valid <= 1;
    do @(posedge clk); while (!item_ready);
    predict_cell(c);
    cells_sent++;
  endtask

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    case (addr)
      ADDR_CONTOUR:  level_q = longint'(signed'(data));
      ADDR_BASE_EN:  base_en_q = data[0];
      ADDR_BASE_LVL: base_q = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic drain;
    item_valid <= 0;
    while (totals_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] lvl, input bit en, input logic [31:0] bl);
    drain();
    reg_write(ADDR_CONTOUR, lvl);
    reg_write(ADDR_BASE_EN, {31'd0, en});
    reg_write(ADDR_BASE_LVL, bl);
  endtask

  function automatic item_t make_cell(int sw, se, ne, nw, bit vld, logic [23:0] w, bit last);
    item_t c;
    c.z_sw = sw; c.z_se = se; c.z_ne = ne; c.z_nw = nw;
    c.cell_valid = vld; c.row_weight = w; c.last_cell = last;
    return c;
  endfunction

  function automatic int near_level(int spread);
    return int'(level_q) + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Extremes, every cell shape, contour touch, invalid cells
  task automatic test_directed;
    set_config(32'd0, 0, 32'd0);
    send_cell(make_cell(100, 200, 300, 400, 1, 24'h010000, 1));
    send_cell(make_cell(-5, -6, -7, -8, 1, 24'hFFFFFF, 1));
    send_cell(make_cell(0, 0, 0, 0, 1, 24'h010000, 0));
    send_cell(make_cell(1, 1, 2, 0, 1, 24'h010000, 1));
    send_cell(make_cell(65536, -65536, 65536, -65536, 1, 24'h010000, 0));
    send_cell(make_cell(-65536, 65536, -65536, 65536, 1, 24'h010000, 1));
    send_cell(make_cell(65536, -100, -100, -100, 1, 24'h008000, 0));
    send_cell(make_cell(-100, 65536, -100, -100, 1, 24'h008000, 0));
    send_cell(make_cell(-100, -100, 65536, -100, 1, 24'h008000, 0));
    send_cell(make_cell(-100, -100, -100, 65536, 1, 24'h008000, 1));
    send_cell(make_cell(65536, 65536, -9000, -9000, 1, 24'h020000, 0));
    send_cell(make_cell(65536, -9000, -9000, 65536, 1, 24'h020000, 0));
    send_cell(make_cell(-65536, -65536, 9000, 9000, 1, 24'h020000, 1));
    send_cell(make_cell(-65536, 5, 5, 5, 1, 24'h010000, 1));
    send_cell(make_cell(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1,
                        24'hFFFFFF, 0));
    send_cell(make_cell(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1,
                        24'hFFFFFF, 0));
    send_cell(make_cell(32'h7FFFFFFF, 3, 4, 5, 0, 24'h000000, 1));
    set_config(32'h80000000, 1, 32'h80000000);
    send_cell(make_cell(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1,
                        24'hFFFFFF, 1));
    set_config(32'h7FFFFFFF, 1, 32'h80000000);
    send_cell(make_cell(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1,
                        24'hFFFFFF, 1));
    send_cell(make_cell(1, 2, 3, 4, 0, 24'h123456, 1));
  endtask

  // Random cells grouped into grids of random length
  task automatic test_random_grids(input int count, input int spread);
    int left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      item_t c;
      if (left == 0) left = $urandom_range(1, 12);
      left--;
      if ($urandom_range(0, 9) == 0) c = item_t'(154'({$urandom, $urandom, $urandom,
                                                       $urandom, $urandom}));
      else begin
        c = make_cell(near_level(spread), near_level(spread), near_level(spread),
                      near_level(spread), $urandom_range(0, 15) != 0,
                      24'($urandom), left == 0);
        if ($urandom_range(0, 7) == 0) c.row_weight = 24'($urandom_range(0, 3)) << 22;
      end
      if (i == count / 2) drain();
      send_cell(c);
    end
  endtask

  task automatic test_random_configs;
    set_config(32'd0, 0, 32'd0);
    test_random_grids(300, 200000);
    set_config($urandom, 1, 32'h80000000);
    test_random_grids(250, 1 << 20);
    set_config(32'h00010000, 1, 32'hFFFF0000);
    test_random_grids(250, 50);
    set_config(32'h00400000, 1, 32'h00500000);
    test_random_grids(100, 1000000);
    set_config(32'hC0000000, 0, $urandom);
    calm = 1;
    test_random_grids(300, 30000000);
  endtask

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    item_valid = 0; item = '0;
    level_q = 0; base_q = 0; base_en_q = 0; vol_acc = 0; area_acc = 0;
    errors = 0; cells_sent = 0; totals_seen = 0; cycles = 0; calm = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random_configs();
    drain();
    $display("Sent %0d cells across 8 contour and base settings; checked %0d totals.",
             cells_sent, totals_seen);
    if (errors == 0) $display("PASS contour_clipped_cell_volume");
    else $display("FAIL contour_clipped_cell_volume");
    $finish;
  end

endmodule
